// ----- rtl/assert_macros.svh -----
// Assertion helpers for the lock order checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define ASSERT(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/loc_pkg.sv -----
package loc_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int NUM_RANKS = 5;
  localparam int RANK_W    = 3;
  localparam int SLOT_W    = 5;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int STATUS_W  = 3;

  localparam logic [RANK_W-1:0]  RANK_NONE = RANK_W'(0);
  localparam logic [RANK_W-1:0]  RANK_MIN  = RANK_W'(1);
  localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(NUM_RANKS);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

  typedef enum logic [0:0] {
    REQ_ENTER = 1'b0,
    REQ_LEAVE = 1'b1
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_INVAL    = 3'd1,
    ST_PERM     = 3'd2,
    ST_ORDER    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [RANK_W-1:0] rank;
    logic              guard_present;
    logic              guard_held;
    logic [SLOT_W-1:0] guard_depth;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0]  top;
    logic [DEPTH_W-1:0] depth;
  } stack_view_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [RANK_W-1:0] rank;
  } stack_upd_t;

endpackage

// ----- rtl/loc_req_if.sv -----
interface loc_req_if;
  import loc_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [RANK_W-1:0] rank;
  logic              guard_present;
  logic              guard_held;
  logic [SLOT_W-1:0] guard_depth;

  modport source (
    output valid, req_type, rank, guard_present, guard_held, guard_depth,
    input  ready
  );

  modport sink (
    input  valid, req_type, rank, guard_present, guard_held, guard_depth,
    output ready
  );
endinterface

// ----- rtl/loc_rsp_if.sv -----
interface loc_rsp_if;
  import loc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_depth;
  logic [RANK_W-1:0]   top_rank;
  logic [DEPTH_W-1:0]  held_count;

  modport source (
    output valid, status, granted_depth, top_rank, held_count,
    input  ready
  );

  modport sink (
    input  valid, status, granted_depth, top_rank, held_count,
    output ready
  );
endinterface

// ----- rtl/loc_decide.sv -----
module loc_decide
  import loc_pkg::*;
(
  input  req_t              req_i,
  input  stack_view_t       cur_i,
  output stack_upd_t        upd_o,
  output status_e           status_o,
  output logic [SLOT_W-1:0] granted_o
);

  logic rank_ok;

  assign rank_ok = (req_i.rank >= RANK_MIN) && (req_i.rank <= RANK_MAX);

  always_comb begin
    upd_o     = '{push: 1'b0, pop: 1'b0, rank: req_i.rank};
    status_o  = ST_OK;
    granted_o = '0;
    if (req_i.req_type == REQ_ENTER) begin
      if (!req_i.guard_present || !rank_ok) begin
        status_o = ST_INVAL;
      end else if (cur_i.top != RANK_NONE && req_i.rank < cur_i.top) begin
        status_o = ST_ORDER;
      end else if (cur_i.depth >= DEPTH_MAX) begin
        status_o = ST_OVERFLOW;
      end else begin
        upd_o.push = 1'b1;
        granted_o  = cur_i.depth[SLOT_W-1:0];
      end
    end else begin
      if (!req_i.guard_present || !req_i.guard_held) begin
        status_o = ST_INVAL;
      end else if (cur_i.depth == '0) begin
        status_o = ST_PERM;
      end else if ((DEPTH_W'(req_i.guard_depth) + DEPTH_W'(1)) != cur_i.depth) begin
        status_o = ST_PERM;
      end else if (cur_i.top != req_i.rank) begin
        status_o = ST_PERM;
      end else begin
        upd_o.pop = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/loc_rank_stack.sv -----
`include "assert_macros.svh"

// Held ranks never decrease from bottom to top, so the stack is fully
// described by a count per rank: the top is the highest rank with a
// non-zero count.
module loc_rank_stack
  import loc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stack_upd_t  upd_i,
  output stack_view_t cur_o,
  output stack_view_t nxt_o
);

  logic [DEPTH_W-1:0] cnt_q [NUM_RANKS];
  logic [DEPTH_W-1:0] cnt_d [NUM_RANKS];
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [RANK_W-1:0]  top_now, top_next;

  always_comb begin
    top_now = RANK_NONE;
    for (int i = 0; i < NUM_RANKS; i++) begin
      if (cnt_q[i] != '0) top_now = RANK_W'(i + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_RANKS; i++) begin
      cnt_d[i] = cnt_q[i]
               + DEPTH_W'(upd_i.push && (upd_i.rank == RANK_W'(i + 1)))
               - DEPTH_W'(upd_i.pop && (top_now == RANK_W'(i + 1)));
    end
    depth_d = depth_q + DEPTH_W'(upd_i.push) - DEPTH_W'(upd_i.pop);
  end

  always_comb begin
    top_next = RANK_NONE;
    for (int i = 0; i < NUM_RANKS; i++) begin
      if (cnt_d[i] != '0) top_next = RANK_W'(i + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      for (int i = 0; i < NUM_RANKS; i++) cnt_q[i] <= '0;
    end else begin
      depth_q <= depth_d;
      for (int i = 0; i < NUM_RANKS; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  assign cur_o = '{top: top_now, depth: depth_q};
  assign nxt_o = '{top: top_next, depth: depth_d};

  `ASSERT(push_pop_excl, !(upd_i.push && upd_i.pop), "push and pop in one cycle")
  `ASSERT(depth_bound, depth_q <= DEPTH_MAX, "stack depth beyond capacity")
  `ASSERT(pop_top_match, upd_i.pop |-> (depth_q != '0 && top_now != RANK_NONE), "pop on empty")
  `ASSERT(push_grows, upd_i.push |=> depth_q == $past(depth_q) + DEPTH_W'(1), "push lost")

endmodule

// ----- rtl/lock_order_stack_checker.sv -----
// Channel  Dir  Payload                                                 Transaction
// req_i    in   req_type, rank, guard_present, guard_held, guard_depth  valid & ready
// rsp_o    out  status, granted_depth, top_rank, held_count             valid & ready
//
// One request per cycle sustained while rsp_o.ready is high; a stalled result holds the flow.
// The request is held in an input register, checked against the rank counters, and the
// outcome lands in the result register while the counters update.
// Reset empties the stack at once; no clearing pass.
// A stalled result holds the input register; req_i.ready drops only when both are full
// and rsp_o.ready is low.
module lock_order_stack_checker
  import loc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  loc_req_if.sink   req_i,
  loc_rsp_if.source rsp_o
);

  logic              in_vld_q;
  req_t              in_q;
  logic              out_vld_q;
  status_e           status_q;
  logic [SLOT_W-1:0] granted_q;
  stack_view_t       view_q;

  logic              advance;
  stack_upd_t        upd_raw, upd;
  status_e           status_d;
  logic [SLOT_W-1:0] granted_d;
  stack_view_t       cur_view, nxt_view;

  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) in_vld_q <= req_i.valid;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= '{req_type:      req_i.req_type,
                rank:          req_i.rank,
                guard_present: req_i.guard_present,
                guard_held:    req_i.guard_held,
                guard_depth:   req_i.guard_depth};
    end
    if (advance) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      view_q    <= nxt_view;
    end
  end

  loc_decide u_decide (
    .req_i     (in_q),
    .cur_i     (cur_view),
    .upd_o     (upd_raw),
    .status_o  (status_d),
    .granted_o (granted_d)
  );

  // state only moves when the transaction is actually retired into the result register
  always_comb begin
    upd      = upd_raw;
    upd.push = upd_raw.push && advance;
    upd.pop  = upd_raw.pop && advance;
  end

  loc_rank_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .cur_o  (cur_view),
    .nxt_o  (nxt_view)
  );

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.granted_depth = granted_q;
  assign rsp_o.top_rank      = view_q.top;
  assign rsp_o.held_count    = view_q.depth;

endmodule
